/* rtl/w2dh_pkg.sv */
// ---------------------------------------------------------------------------
// w2dh_pkg
// Shared types and constants of the weighted two-dimensional histogram.
// ---------------------------------------------------------------------------
package w2dh_pkg;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_XMUL,
		ST_XLOAD,
		ST_XDIV,
		ST_XCHK,
		ST_YMUL,
		ST_YLOAD,
		ST_YDIV,
		ST_YCHK,
		ST_ADDR,
		ST_MRD,
		ST_RDOUT,
		ST_WLOAD,
		ST_WDIV,
		ST_WRITE,
		ST_DONE
	} w2dh_state_t;

	// Command codes.
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Result status codes.
	localparam logic [2:0] STAT_ADDED        = 3'd0;
	localparam logic [2:0] STAT_BURN_IN      = 3'd1;
	localparam logic [2:0] STAT_OUT_OF_RANGE = 3'd2;
	localparam logic [2:0] STAT_ZERO_DIV     = 3'd3;
	localparam logic [2:0] STAT_READ         = 3'd4;

	// Register map: index is the word address.
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_BURN_IN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_X_LOWER = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_X_UPPER = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_LOWER = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_Y_UPPER = 3'd4;

	localparam logic signed [31:0] BOUND_LOWER_RST = 32'sd0;
	localparam logic signed [31:0] BOUND_UPPER_RST = 32'sd65536;

	// Shared restoring divider: 41-bit dividend, 33-bit divisor.
	localparam int DIV_NUM_W  = 41;
	localparam int DIV_DEN_W  = 33;
	localparam int DIV_REM_W  = 34;
	localparam int DIV_CNT_W  = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 6'd40;
	localparam logic [DIV_NUM_W-1:0] WEIGHT_DIVIDEND = 41'h100_0000_0000;

	localparam int TOTAL_W = 48;

endpackage

/* rtl/weighted_2d_histogram.sv */
// ---------------------------------------------------------------------------
// weighted_2d_histogram
// Bins weighted chain samples into an X_BINS by Y_BINS store and reads bins.
// ---------------------------------------------------------------------------
// Use of the block.
// A transaction is offered on start with command and its payload, and is
// taken at the rising edge where start is high and busy is low. An add
// command bins the sample on both axes and adds 2^40/weight_divisor into the
// bin, saturating at 2^48-1; a read command returns one bin. Every
// transaction gives exactly one result, shown on status, bin_col, bin_row and
// bin_total for the single cycle in which done is high. The receiver cannot
// hold a result off, so it must sample it in that cycle.
// An add that reaches the store goes through three 41-step passes of the
// one shared restoring divider (x bin, y bin, weight), and a new start is
// taken only once the block is back in idle after done. A read passes
// through a store read and a readout state before done; burn-in skips and
// refused reads show done in the cycle after acceptance.
// Reset clears the configuration registers, state and sample count, then a
// clearing pass writes zero to all X_BINS*Y_BINS store entries, one per
// cycle, with busy high. Configuration writes over APB are taken at any time.
// ---------------------------------------------------------------------------
module weighted_2d_histogram
	import w2dh_pkg::*;
#(
	parameter int X_BINS = 128,
	parameter int Y_BINS = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// Command channel
	input  logic                 start,
	output logic                 busy,
	input  logic                 command,
	input  logic signed [31:0]   x_value,
	input  logic signed [31:0]   y_value,
	input  logic [31:0]          weight_divisor,
	input  logic [6:0]           read_col,
	input  logic [6:0]           read_row,
	// Result channel
	output logic                 done,
	output logic [2:0]           status,
	output logic [6:0]           bin_col,
	output logic [6:0]           bin_row,
	output logic [TOTAL_W-1:0]   bin_total
);

	localparam int DEPTH = X_BINS * Y_BINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XB_W  = $clog2(X_BINS);
	localparam int YB_W  = $clog2(Y_BINS);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
	localparam logic signed [8:0] X_K = 9'(X_BINS - 1);
	localparam logic signed [8:0] Y_K = 9'(Y_BINS - 1);
	localparam logic [DIV_NUM_W-1:0] X_MAX_BIN = DIV_NUM_W'(X_BINS - 1);
	localparam logic [DIV_NUM_W-1:0] Y_MAX_BIN = DIV_NUM_W'(Y_BINS - 1);

	// Configuration registers.
	logic [31:0]        burn_in_q;
	logic signed [31:0] x_lower_q;
	logic signed [31:0] x_upper_q;
	logic signed [31:0] y_lower_q;
	logic signed [31:0] y_upper_q;

	// Sequencer and control state.
	w2dh_state_t          state_q;
	w2dh_state_t          state_d;
	logic [AW-1:0]        clr_q;
	logic [31:0]          sample_cnt_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// Latched transaction.
	logic               cmd_q;
	logic signed [31:0] x_value_q;
	logic signed [31:0] y_value_q;
	logic [31:0]        weight_q;
	logic [6:0]         rcol_q;
	logic [6:0]         rrow_q;

	// Datapath registers.
	logic signed [41:0]   prod_q;
	logic signed [32:0]   den_q;
	logic [DIV_NUM_W-1:0] div_num_q;
	logic [DIV_DEN_W-1:0] div_den_q;
	logic [DIV_REM_W-1:0] div_rem_q;
	logic                 div_neg_q;
	logic [XB_W-1:0]      xb_q;
	logic [YB_W-1:0]      yb_q;
	logic [AW-1:0]        addr_q;
	logic [TOTAL_W-1:0]   mem_rdata_q;

	// Result registers.
	logic [2:0]         status_q;
	logic [6:0]         col_q;
	logic [6:0]         row_q;
	logic [TOTAL_W-1:0] total_q;

	// Bin store.
	logic [TOTAL_W-1:0] mem [DEPTH];

	// Combinational signals.
	logic                 accept;
	logic                 reg_we;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 rd_oor;
	logic                 in_burn_in;
	logic                 axis_y;
	logic signed [31:0]   mul_v;
	logic signed [31:0]   mul_lo;
	logic signed [31:0]   mul_hi;
	logic signed [8:0]    mul_k;
	logic signed [32:0]   mul_diff;
	logic signed [41:0]   mul_prod;
	logic signed [32:0]   mul_den;
	logic [DIV_NUM_W-1:0] prod_mag;
	logic [DIV_DEN_W-1:0] den_mag;
	logic [DIV_REM_W-1:0] div_trial;
	logic [DIV_REM_W:0]   div_diff;
	logic                 div_ge;
	logic                 axis_oor;
	logic [TOTAL_W:0]     acc_sum;
	logic [TOTAL_W-1:0]   acc_sat;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        bin_addr;

	// Sequencer outputs.
	logic               div_load;
	logic [DIV_NUM_W-1:0] div_num_d;
	logic [DIV_DEN_W-1:0] div_den_d;
	logic               div_neg_d;
	logic               div_step;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [TOTAL_W-1:0] mem_wdata;
	logic               res_we;
	logic [2:0]         res_status;
	logic [6:0]         res_col;
	logic [6:0]         res_row;
	logic [TOTAL_W-1:0] res_total;

	// ------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; reads of an
	// address past the last register return zero.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign reg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burn_in_q <= '0;
			x_lower_q <= BOUND_LOWER_RST;
			x_upper_q <= BOUND_UPPER_RST;
			y_lower_q <= BOUND_LOWER_RST;
			y_upper_q <= BOUND_UPPER_RST;
		end else if (reg_we) begin
			case (reg_idx)
				REG_BURN_IN: burn_in_q <= pwdata;
				REG_X_LOWER: x_lower_q <= pwdata;
				REG_X_UPPER: x_upper_q <= pwdata;
				REG_Y_LOWER: y_lower_q <= pwdata;
				REG_Y_UPPER: y_upper_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BURN_IN: prdata = burn_in_q;
			REG_X_LOWER: prdata = x_lower_q;
			REG_X_UPPER: prdata = x_upper_q;
			REG_Y_LOWER: prdata = y_lower_q;
			REG_Y_UPPER: prdata = y_upper_q;
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Decisions taken at acceptance.
	// ------------------------------------------------------------------
	assign accept     = start && !busy;
	assign rd_oor     = (32'(read_col) >= X_BINS) || (32'(read_row) >= Y_BINS);
	assign in_burn_in = sample_cnt_q <= burn_in_q;
	assign rd_addr    = AW'(read_row) * AW'(X_BINS) + AW'(read_col);
	assign bin_addr   = AW'(yb_q) * AW'(X_BINS) + AW'(xb_q);

	// ------------------------------------------------------------------
	// Shared multiplier: (BINS-1)*(v-lower) for whichever axis is active,
	// together with the span upper-lower.
	// ------------------------------------------------------------------
	assign axis_y   = (state_q == ST_YMUL);
	assign mul_v    = axis_y ? y_value_q : x_value_q;
	assign mul_lo   = axis_y ? y_lower_q : x_lower_q;
	assign mul_hi   = axis_y ? y_upper_q : x_upper_q;
	assign mul_k    = axis_y ? Y_K : X_K;
	assign mul_diff = 33'(mul_v) - 33'(mul_lo);
	assign mul_prod = mul_diff * mul_k;
	assign mul_den  = 33'(mul_hi) - 33'(mul_lo);

	// Magnitudes for the unsigned divider; the sign is carried aside.
	assign prod_mag = prod_q[41] ? DIV_NUM_W'(-prod_q) : DIV_NUM_W'(prod_q);
	assign den_mag  = den_q[32] ? DIV_DEN_W'(-den_q) : DIV_DEN_W'(den_q);

	// ------------------------------------------------------------------
	// Restoring divider step: one quotient bit per cycle, the dividend
	// register shifting out towards the remainder and filling with quotient.
	// ------------------------------------------------------------------
	assign div_trial = {div_rem_q[DIV_REM_W-2:0], div_num_q[DIV_NUM_W-1]};
	assign div_diff  = {1'b0, div_trial} - {2'b00, div_den_q};
	assign div_ge    = !div_diff[DIV_REM_W];

	// A truncated quotient is out of range when negative and non-zero, or
	// when it passes the last bin of its axis.
	always_comb begin
		if (state_q == ST_YCHK) begin
			axis_oor = (div_neg_q && (div_num_q != '0)) || (div_num_q > Y_MAX_BIN);
		end else begin
			axis_oor = (div_neg_q && (div_num_q != '0)) || (div_num_q > X_MAX_BIN);
		end
	end

	// Saturating accumulate of the weight into the bin read from the store.
	assign acc_sum = {1'b0, mem_rdata_q} + (TOTAL_W + 1)'(div_num_q);
	assign acc_sat = acc_sum[TOTAL_W] ? '1 : acc_sum[TOTAL_W-1:0];

	// ------------------------------------------------------------------
	// Sequencer: next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_READ) begin
						state_d = rd_oor ? ST_DONE : ST_MRD;
					end else begin
						state_d = in_burn_in ? ST_DONE : ST_XMUL;
					end
				end
			end
			ST_XMUL:  state_d = ST_XLOAD;
			ST_XLOAD: state_d = (den_q == '0) ? ST_DONE : ST_XDIV;
			ST_XDIV: begin
				if (div_cnt_q == '0) state_d = ST_XCHK;
			end
			ST_XCHK:  state_d = axis_oor ? ST_DONE : ST_YMUL;
			ST_YMUL:  state_d = ST_YLOAD;
			ST_YLOAD: state_d = (den_q == '0) ? ST_DONE : ST_YDIV;
			ST_YDIV: begin
				if (div_cnt_q == '0) state_d = ST_YCHK;
			end
			ST_YCHK:  state_d = axis_oor ? ST_DONE : ST_ADDR;
			ST_ADDR:  state_d = ST_MRD;
			ST_MRD:   state_d = (cmd_q == CMD_READ) ? ST_RDOUT : ST_WLOAD;
			ST_RDOUT: state_d = ST_DONE;
			ST_WLOAD: state_d = (weight_q == '0) ? ST_DONE : ST_WDIV;
			ST_WDIV: begin
				if (div_cnt_q == '0) state_d = ST_WRITE;
			end
			ST_WRITE: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs.
	// ------------------------------------------------------------------
	always_comb begin
		div_load   = 1'b0;
		div_num_d  = prod_mag;
		div_den_d  = den_mag;
		div_neg_d  = prod_q[41] ^ den_q[32];
		div_step   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = addr_q;
		mem_wdata  = acc_sat;
		res_we     = 1'b0;
		res_status = STAT_OUT_OF_RANGE;
		res_col    = '0;
		res_row    = '0;
		res_total  = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_READ) begin
						res_we  = rd_oor;
						res_col = read_col;
						res_row = read_row;
					end else begin
						res_we     = in_burn_in;
						res_status = STAT_BURN_IN;
					end
				end
			end
			ST_XLOAD, ST_YLOAD: begin
				div_load = (den_q != '0);
				res_we   = (den_q == '0);
			end
			ST_XDIV, ST_YDIV, ST_WDIV: begin
				div_step = 1'b1;
			end
			ST_XCHK, ST_YCHK: begin
				res_we = axis_oor;
			end
			ST_RDOUT: begin
				res_we     = 1'b1;
				res_status = STAT_READ;
				res_col    = rcol_q;
				res_row    = rrow_q;
				res_total  = mem_rdata_q;
			end
			ST_WLOAD: begin
				div_load   = (weight_q != '0);
				div_num_d  = WEIGHT_DIVIDEND;
				div_den_d  = DIV_DEN_W'(weight_q);
				div_neg_d  = 1'b0;
				res_we     = (weight_q == '0);
				res_status = STAT_ZERO_DIV;
				res_col    = 7'(xb_q);
				res_row    = 7'(yb_q);
				res_total  = mem_rdata_q;
			end
			ST_WRITE: begin
				mem_we     = 1'b1;
				res_we     = 1'b1;
				res_status = STAT_ADDED;
				res_col    = 7'(xb_q);
				res_row    = 7'(yb_q);
				res_total  = acc_sat;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			sample_cnt_q <= '0;
			div_cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			// Every add command counts, whatever its outcome; the count sticks
			// at its maximum.
			if (accept && (command == CMD_ADD) && (sample_cnt_q != '1)) begin
				sample_cnt_q <= sample_cnt_q + 1'b1;
			end
			if (div_load) begin
				div_cnt_q <= DIV_LAST_STEP;
			end else if (div_step && (div_cnt_q != '0)) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= command;
			x_value_q <= x_value;
			y_value_q <= y_value;
			weight_q  <= weight_divisor;
			rcol_q    <= read_col;
			rrow_q    <= read_row;
			addr_q    <= rd_addr;
		end
		if ((state_q == ST_XMUL) || (state_q == ST_YMUL)) begin
			prod_q <= mul_prod;
			den_q  <= mul_den;
		end
		if (div_load) begin
			div_num_q <= div_num_d;
			div_den_q <= div_den_d;
			div_rem_q <= '0;
			div_neg_q <= div_neg_d;
		end else if (div_step) begin
			div_num_q <= {div_num_q[DIV_NUM_W-2:0], div_ge};
			div_rem_q <= div_ge ? div_diff[DIV_REM_W-1:0] : div_trial;
		end
		if (state_q == ST_XCHK) xb_q <= XB_W'(div_num_q);
		if (state_q == ST_YCHK) yb_q <= YB_W'(div_num_q);
		if (state_q == ST_ADDR) addr_q <= bin_addr;
		if (res_we) begin
			status_q <= res_status;
			col_q    <= res_col;
			row_q    <= res_row;
			total_q  <= res_total;
		end
	end

	// ------------------------------------------------------------------
	// Bin store: one write port, one registered read port at addr_q.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[addr_q];
	end

	assign status    = status_q;
	assign bin_col   = col_q;
	assign bin_row   = row_q;
	assign bin_total = total_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && !done) || (done && $past(command == CMD_READ || in_burn_in)))
		else $error("accepted transaction did not occupy the block");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> sample_cnt_q >= $past(sample_cnt_q))
		else $error("sample count went backwards");

	a_write_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (weight_q != '0) && (div_cnt_q == '0))
		else $error("store written without a finished weight division");

	a_added_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_ADDED)) |-> (bin_total != '0))
		else $error("added sample left its bin empty");

endmodule

/* dv/tb_weighted_2d_histogram.sv */
// ---------------------------------------------------------------------------
// tb_weighted_2d_histogram
// Self-checking testbench for the weighted two-dimensional histogram. A short
// directed table covers reads, burn-in, the axis extremes, zero divisors and
// odd bounds. Random phases follow, each with its own register setting, and
// one phase hammers a single bin until it saturates. Every result is checked
// against a typed-in outcome or a predictor of the binning arithmetic and bin store.
// ---------------------------------------------------------------------------
module tb_weighted_2d_histogram;
	import w2dh_pkg::*;

	localparam int X_BINS = 128;
	localparam int Y_BINS = 128;
	// The clearing pass after reset clears one bin per cycle, which far outlasts
	// the longest quiet stretch of a correct run (a long gap plus one add).
	localparam int STALL_LIMIT = 100000;
	localparam int NUM_PHASES = 10;
	localparam int SATURATION_PHASE = 5;
	localparam int DRAIN_CYCLES = 300;
	// Under the reset bounds these land in bin column 15, row 95.
	localparam logic [31:0] HAMMER_X = 32'h0000_2000;
	localparam logic [31:0] HAMMER_Y = 32'h0000_C000;
	localparam logic [63:0] TOTAL_MAX = 64'hFFFF_FFFF_FFFF;

	typedef struct {
		logic               cmd;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        div;
		logic [6:0]         col;
		logic [6:0]         row;
	} sample_t;

	typedef struct {
		logic [2:0]         status;
		logic [6:0]         col;
		logic [6:0]         row;
		logic [TOTAL_W-1:0] total;
	} outcome_t;

	typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [REG_IDX_W-1:0]   reg_idx;
		logic [31:0]            reg_val;
		sample_t                s;
		bit                     known;
		outcome_t               want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 start;
	logic                 busy;
	logic                 command;
	logic signed [31:0]   x_value;
	logic signed [31:0]   y_value;
	logic [31:0]          weight_divisor;
	logic [6:0]           read_col;
	logic [6:0]           read_row;
	logic                 done;
	logic [2:0]           status;
	logic [6:0]           bin_col;
	logic [6:0]           bin_row;
	logic [TOTAL_W-1:0]   bin_total;

	// Predictor state: a copy of the registers, the sample count and the bins.
	logic [31:0]          cfg_burn_in = 32'd0;
	logic signed [31:0]   cfg_x_lo = BOUND_LOWER_RST;
	logic signed [31:0]   cfg_x_hi = BOUND_UPPER_RST;
	logic signed [31:0]   cfg_y_lo = BOUND_LOWER_RST;
	logic signed [31:0]   cfg_y_hi = BOUND_UPPER_RST;
	logic [31:0]          seen_samples = 32'd0;
	bit [TOTAL_W-1:0]     hist_model [0:X_BINS*Y_BINS-1];

	outcome_t             pending_results [$];
	plan_row_t            plan [$];
	bit                   cur_known;
	outcome_t             cur_want;
	logic [6:0]           last_col = 7'd0;
	logic [6:0]           last_row = 7'd0;
	int                   burst_left = 0;
	int                   errors = 0;

	weighted_2d_histogram #(
		.X_BINS(X_BINS),
		.Y_BINS(Y_BINS)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.x_value        (x_value),
		.y_value        (y_value),
		.weight_divisor (weight_divisor),
		.read_col       (read_col),
		.read_row       (read_row),
		.done           (done),
		.status         (status),
		.bin_col        (bin_col),
		.bin_row        (bin_row),
		.bin_total      (bin_total)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Maps a value onto one axis. The quotient truncates toward zero, so a
	// value a little below the lower bound still falls into bin zero, and
	// reversed bounds work through the same signed division.
	function automatic bit locate_bin(input logic signed [31:0] v, lo, hi,
			input int n_bins, output longint bin);
		longint span;
		longint q;
		bin = 0;
		span = longint'(hi) - longint'(lo);
		if (span == 0)
			return 1'b0;
		q = (longint'(n_bins - 1) * (longint'(v) - longint'(lo))) / span;
		if (q < 0 || q > n_bins - 1)
			return 1'b0;
		bin = q;
		return 1'b1;
	endfunction

	// Works out the result of one transaction and updates the predicted bins.
	function automatic outcome_t histogram_step(input sample_t s);
		outcome_t   o;
		logic [31:0] idx;
		longint     xb;
		longint     yb;
		int         addr;
		logic [63:0] sum;
		o.status = STAT_ADDED;
		o.col = '0;
		o.row = '0;
		o.total = '0;
		if (s.cmd == CMD_READ) begin
			o.status = STAT_READ;
			o.col = s.col;
			o.row = s.row;
			o.total = hist_model[int'(s.row) * X_BINS + int'(s.col)];
			return o;
		end
		idx = seen_samples;
		if (seen_samples != 32'hFFFF_FFFF)
			seen_samples++;
		if (idx <= cfg_burn_in) begin
			o.status = STAT_BURN_IN;
			return o;
		end
		if (!locate_bin(s.x, cfg_x_lo, cfg_x_hi, X_BINS, xb) ||
				!locate_bin(s.y, cfg_y_lo, cfg_y_hi, Y_BINS, yb)) begin
			o.status = STAT_OUT_OF_RANGE;
			return o;
		end
		addr = int'(yb) * X_BINS + int'(xb);
		o.col = xb[6:0];
		o.row = yb[6:0];
		if (s.div == 32'd0) begin
			o.status = STAT_ZERO_DIV;
			o.total = hist_model[addr];
			return o;
		end
		sum = {16'd0, hist_model[addr]} + ((64'd1 << 40) / {32'd0, s.div});
		if (sum > TOTAL_MAX)
			sum = TOTAL_MAX;
		hist_model[addr] = sum[TOTAL_W-1:0];
		o.total = sum[TOTAL_W-1:0];
		return o;
	endfunction

	task automatic compare_field(input string what, input logic [47:0] want, got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
			errors++;
		end
	endtask

	// Table rows. A row with a known outcome carries it typed in; the
	// predictor still runs on it so that the sample count and bins stay in step.
	function automatic void plan_item(input logic cmd, input logic [31:0] x, y, div,
			input logic [6:0] col, row);
		plan_row_t r;
		r.kind = ROW_ITEM;
		r.reg_idx = REG_BURN_IN;
		r.reg_val = '0;
		r.s.cmd = cmd;
		r.s.x = x;
		r.s.y = y;
		r.s.div = div;
		r.s.col = col;
		r.s.row = row;
		r.known = 1'b0;
		r.want.status = STAT_ADDED;
		r.want.col = '0;
		r.want.row = '0;
		r.want.total = '0;
		plan.push_back(r);
	endfunction

	function automatic void plan_known(input logic cmd, input logic [31:0] x, y, div,
			input logic [6:0] col, row, input logic [2:0] st,
			input logic [6:0] bc, br, input logic [47:0] tot);
		int n;
		plan_item(cmd, x, y, div, col, row);
		n = plan.size() - 1;
		plan[n].known = 1'b1;
		plan[n].want.status = st;
		plan[n].want.col = bc;
		plan[n].want.row = br;
		plan[n].want.total = tot;
	endfunction

	function automatic void plan_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		plan_item(CMD_ADD, '0, '0, '0, '0, '0);
		plan[plan.size() - 1].kind = ROW_REG;
		plan[plan.size() - 1].reg_idx = idx;
		plan[plan.size() - 1].reg_val = val;
	endfunction

	// Writes one register, reads it straight back, and brings the predictor's
	// copy up to date. Only ever called while the block is idle.
	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		compare_field("prdata", {16'd0, val}, {16'd0, prdata});
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
			REG_BURN_IN: cfg_burn_in = val;
			REG_X_LOWER: cfg_x_lo = val;
			REG_X_UPPER: cfg_x_hi = val;
			REG_Y_LOWER: cfg_y_lo = val;
			REG_Y_UPPER: cfg_y_hi = val;
			default: ;
		endcase
	endtask

	// Offers one transaction and holds it until the block takes it.
	task automatic send_item(input sample_t s, input bit known, input outcome_t want);
		@(negedge clk);
		start = 1'b1;
		command = s.cmd;
		x_value = s.x;
		y_value = s.y;
		weight_divisor = s.div;
		read_col = s.col;
		read_row = s.row;
		cur_known = known;
		cur_want = want;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// The sender works in bursts; between bursts start drops for a while,
	// sometimes briefly and sometimes for longer than a whole add.
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 6);
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		burst_left--;
	endtask

	// Stops offering and waits until every expected result is in and the
	// block has gone idle. Every transaction gives a result, so nothing can
	// still be at work once the queue is empty and busy is low.
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0 || busy) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Picks a value for one axis: mostly spread over the bounds (and a
	// little past the upper one, where the last bin lives), sometimes just
	// outside them, sometimes anything at all.
	function automatic logic [31:0] axis_value(input logic signed [31:0] lo, hi);
		longint span;
		longint v;
		span = longint'(hi) - longint'(lo);
		case ($urandom_range(0, 19))
			0, 1: v = longint'(lo) - longint'($urandom_range(0, 700));
			2, 3: v = longint'(hi) + longint'($urandom_range(0, 700)) - 64'sd350;
			4: v = longint'($urandom);
			default: v = longint'(lo) + (span * longint'($urandom_range(0, 1007874))) / 1000000;
		endcase
		return v[31:0];
	endfunction

	task automatic draw_sample(input bit hammer, output sample_t s);
		s.cmd = CMD_ADD;
		s.col = 7'($urandom_range(0, 127));
		s.row = 7'($urandom_range(0, 127));
		s.x = axis_value(cfg_x_lo, cfg_x_hi);
		s.y = axis_value(cfg_y_lo, cfg_y_hi);
		case ($urandom_range(0, 19))
			0: s.div = 32'd0;
			1, 2: s.div = $urandom_range(1, 16);
			3, 4: s.div = $urandom;
			5: s.div = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
			default: s.div = $urandom_range(1, 32'h0010_0000);
		endcase
		if (hammer) begin
			// Full weight into one bin, so it runs into saturation.
			s.x = HAMMER_X;
			s.y = HAMMER_Y;
			s.div = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : 32'd1;
			if ($urandom_range(0, 9) == 0) begin
				s.cmd = CMD_READ;
				s.col = last_col;
				s.row = last_row;
			end
		end else if ($urandom_range(0, 3) == 0) begin
			s.cmd = CMD_READ;
			if ($urandom_range(0, 1) == 0) begin
				s.col = last_col;
				s.row = last_row;
			end
		end
	endtask

	// Sets the registers for one random phase. The first phases visit the
	// extremes; the later ones, but for the saturation phase, pick bounds at random.
	task automatic configure_phase(input int p);
		logic [31:0] burn;
		logic [31:0] xl;
		logic [31:0] xh;
		logic [31:0] yl;
		logic [31:0] yh;
		burn = 32'd0;
		xl = BOUND_LOWER_RST;
		xh = BOUND_UPPER_RST;
		yl = BOUND_LOWER_RST;
		yh = BOUND_UPPER_RST;
		case (p)
			0: burn = seen_samples + 32'd8;
			1: begin
				xl = 32'h8000_0000;
				xh = 32'h7FFF_FFFF;
				yl = -32'sd196608;
				yh = 32'sd327680;
			end
			2: begin
				xl = 32'h7FFF_FFFF;
				xh = 32'h8000_0000;
				yl = 32'sd65536;
				yh = -32'sd65536;
			end
			3: burn = 32'hFFFF_FFFF;
			4: begin
				yl = $urandom;
				yh = yl;
			end
			SATURATION_PHASE: ;
			default: begin
				burn = seen_samples + $urandom_range(0, 5);
				xl = $urandom;
				xh = $urandom_range(0, 1) ? xl + $urandom_range(64, 32'h0100_0000)
					: xl - $urandom_range(64, 32'h0100_0000);
				yl = $urandom;
				yh = ($urandom_range(0, 3) == 0) ? $urandom : yl + $urandom_range(64, 32'h0001_0000);
			end
		endcase
		write_register(REG_BURN_IN, burn);
		write_register(REG_X_LOWER, xl);
		write_register(REG_X_UPPER, xh);
		write_register(REG_Y_LOWER, yl);
		write_register(REG_Y_UPPER, yh);
	endtask

	// Result side. At each rising edge an accepted transaction is predicted
	// and queued, and a strobed result is checked against the oldest entry.
	always @(posedge clk) begin : result_check
		sample_t  s;
		outcome_t o;
		if (start && !busy) begin
			s.cmd = command;
			s.x = x_value;
			s.y = y_value;
			s.div = weight_divisor;
			s.col = read_col;
			s.row = read_row;
			o = histogram_step(s);
			if (o.status == STAT_ADDED) begin
				last_col = o.col;
				last_row = o.row;
			end
			if (cur_known)
				o = cur_want;
			pending_results.push_back(o);
		end
		if (done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: status %0d, bin %0d/%0d, total 0x%0h",
					$time, status, bin_col, bin_row, bin_total);
				errors++;
			end else begin
				o = pending_results.pop_front();
				compare_field("status", {45'd0, o.status}, {45'd0, status});
				compare_field("bin_col", {41'd0, o.col}, {41'd0, bin_col});
				compare_field("bin_row", {41'd0, o.row}, {41'd0, bin_row});
				compare_field("bin_total", o.total, bin_total);
			end
		end
	end

	// Ends the run if neither side moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		sample_t  s;
		outcome_t none;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		command = CMD_ADD;
		x_value = '0;
		y_value = '0;
		weight_divisor = '0;
		read_col = '0;
		read_row = '0;
		cur_known = 1'b0;
		none.status = STAT_ADDED;
		none.col = '0;
		none.row = '0;
		none.total = '0;
		cur_want = none;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Let the clearing pass of the bin store run to its end.
		repeat (2) @(negedge clk);
		while (busy) @(negedge clk);

		// Directed table. Under the reset bounds one unit (65536) spans the
		// axis, so bin = 127*v/65536 and a divisor of 1.0 adds 2^24.
		plan_known(CMD_READ, 0, 0, 0, 7'd0, 7'd0, STAT_READ, 7'd0, 7'd0, 48'd0);
		plan_known(CMD_READ, 0, 0, 0, 7'd127, 7'd127, STAT_READ, 7'd127, 7'd127, 48'd0);
		// The very first sample has index 0, which never exceeds the burn-in.
		plan_known(CMD_ADD, 0, 0, 32'h0001_0000, 7'd0, 7'd0, STAT_BURN_IN, 7'd0, 7'd0, 48'd0);
		plan_known(CMD_ADD, 0, 0, 32'h0001_0000, 7'd0, 7'd0,
			STAT_ADDED, 7'd0, 7'd0, 48'h00_0001_00_0000);
		plan_known(CMD_ADD, 32'h0001_0000, 32'h0001_0000, 32'd1, 7'd0, 7'd0,
			STAT_ADDED, 7'd127, 7'd127, 48'h0100_0000_0000);
		plan_known(CMD_ADD, 32'h7FFF_FFFF, 0, 32'd5, 7'd0, 7'd0,
			STAT_OUT_OF_RANGE, 7'd0, 7'd0, 48'd0);
		plan_known(CMD_ADD, 32'h8000_0000, 0, 32'd5, 7'd0, 7'd0,
			STAT_OUT_OF_RANGE, 7'd0, 7'd0, 48'd0);
		plan_known(CMD_ADD, 0, 32'h7FFF_FFFF, 32'd5, 7'd0, 7'd0,
			STAT_OUT_OF_RANGE, 7'd0, 7'd0, 48'd0);
		plan_known(CMD_ADD, 0, 32'h8000_0000, 32'd5, 7'd0, 7'd0,
			STAT_OUT_OF_RANGE, 7'd0, 7'd0, 48'd0);
		// Zero divisor: the bin is named but left as it was.
		plan_known(CMD_ADD, 0, 0, 32'd0, 7'd0, 7'd0,
			STAT_ZERO_DIV, 7'd0, 7'd0, 48'h00_0001_00_0000);
		// Just below the lower bound still truncates into bin zero.
		plan_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0, 7'd0);
		plan_item(CMD_ADD, 32'h0000_8000, 32'h0000_4000, 32'd3, 7'd0, 7'd0);
		plan_item(CMD_ADD, 32'h0000_FFFF, 32'h0001_0203, 32'h0000_8000, 7'd0, 7'd0);
		plan_item(CMD_READ, 0, 0, 0, 7'd0, 7'd0);
		plan_item(CMD_READ, 0, 0, 0, 7'd63, 7'd31);
		plan_item(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h55, 7'h2A);
		// Equal bounds on x leave no bin to land in.
		plan_reg(REG_X_UPPER, 32'd0);
		plan_known(CMD_ADD, 0, 0, 32'h0001_0000, 7'd0, 7'd0,
			STAT_OUT_OF_RANGE, 7'd0, 7'd0, 48'd0);
		// Reversed bounds on x mirror the axis.
		plan_reg(REG_X_LOWER, 32'h0001_0000);
		plan_item(CMD_ADD, 0, 0, 32'h0001_0000, 7'd0, 7'd0);
		plan_item(CMD_ADD, 32'h0001_0000, 32'h0000_2000, 32'h0000_0100, 7'd0, 7'd0);
		plan_item(CMD_ADD, 32'h0001_1170, 32'h0000_2000, 32'h0000_0100, 7'd0, 7'd0);
		plan_reg(REG_X_LOWER, 32'd0);
		plan_reg(REG_X_UPPER, 32'h0001_0000);
		// The largest burn-in count skips every sample.
		plan_reg(REG_BURN_IN, 32'hFFFF_FFFF);
		plan_known(CMD_ADD, 0, 0, 32'h0001_0000, 7'd0, 7'd0, STAT_BURN_IN, 7'd0, 7'd0, 48'd0);
		plan_reg(REG_BURN_IN, 32'd0);
		plan_item(CMD_READ, 0, 0, 0, 7'd127, 7'd127);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_idle();
				write_register(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				pace();
				send_item(plan[i].s, plan[i].known, plan[i].want);
			end
		end

		// Random phases. Each one starts from an idle block with every
		// result in, which also gives the sender its full pause.
		for (int p = 0; p < NUM_PHASES; p++) begin
			int items;
			wait_idle();
			configure_phase(p);
			case (p)
				3: items = 25;
				4: items = 30;
				SATURATION_PHASE: items = 330;
				1, 2: items = 110;
				default: items = 100;
			endcase
			for (int n = 0; n < items; n++) begin
				draw_sample(p == SATURATION_PHASE, s);
				pace();
				send_item(s, 1'b0, none);
			end
		end

		wait_idle();
		// Watch a little longer for any stray result.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
